@@ hw/rtl/sws_pkg.sv @@
// Shared types and constants for the sliding-window statistics core.
package sws_pkg;

  // Configuration register map
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_ADDR_W     = 3;
  localparam int WIN_REG_W      = 5;
  localparam logic [WIN_REG_W-1:0] WIN_REG_RESET = 5'd4;
  localparam logic REG_WINDOW_SIZE = 1'b0;

  // Per-beat flags passed from the classifier to the execution side
  typedef struct packed {
    logic produce;
    logic last;
  } job_flags_t;

  localparam int JOB_FLAGS_W = $bits(job_flags_t);

  // Execution sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_ABS,
    BK_DIV,
    BK_OUT
  } back_state_t;

endpackage

@@ hw/rtl/sws_if.sv @@
// Stream interfaces for the sample input and the statistics output.
interface sws_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          is_last;

  modport source (output valid, output sample, output is_last, input ready);
  modport sink   (input valid, input sample, input is_last, output ready);
endinterface

interface sws_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] window_max;
  logic signed [SAMPLE_BITS-1:0] window_min;
  logic signed [SAMPLE_BITS-1:0] window_middle;
  logic signed [SAMPLE_BITS-1:0] window_average;
  logic                          end_of_sequence;

  modport source (output valid, output window_max, output window_min,
                  output window_middle, output window_average,
                  output end_of_sequence, input ready);
  modport sink   (input valid, input window_max, input window_min,
                  input window_middle, input window_average,
                  input end_of_sequence, output ready);
endinterface

@@ hw/rtl/sws_front.sv @@
// Front end: accepts sample beats, tracks window fill and flags result beats.
module sws_front
  import sws_pkg::*;
#(
  parameter int WINDOW_MAX  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [$clog2(WINDOW_MAX+1)-1:0] eff_w,
  input  logic                          cfg_clear,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_is_last,
  output logic                          push_valid,
  input  logic                          push_ready,
  output logic [JOB_FLAGS_W+SAMPLE_BITS-1:0] push_data
);

  localparam int WIN_W = $clog2(WINDOW_MAX+1);

  logic [WIN_W-1:0] fill_r, fill_nxt;
  logic [WIN_W-1:0] fill_held;
  logic [WIN_W-1:0] fill_new;
  logic             accept;
  job_flags_t       flags;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  // Oldest sample drops out once the window is full
  assign fill_held = (fill_r >= eff_w) ? (eff_w - WIN_W'(1)) : fill_r;
  assign fill_new  = fill_held + WIN_W'(1);

  assign flags.produce = (fill_new == eff_w);
  assign flags.last    = in_is_last;
  assign push_data     = {flags, in_sample};

  always_comb begin
    fill_nxt = fill_r;
    if (cfg_clear) begin
      fill_nxt = '0;
    end else if (accept) begin
      fill_nxt = in_is_last ? '0 : fill_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

endmodule

@@ hw/rtl/sws_queue.sv @@
// Two-entry queue between the front end and the execution side.
module sws_queue #(
  parameter int DATA_W = 18
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data
);

  logic [DATA_W-1:0] mem_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hw/rtl/sws_back.sv @@
// Execution side: sample history, window scan, iterative average divider.
module sws_back
  import sws_pkg::*;
#(
  parameter int WINDOW_MAX  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [$clog2(WINDOW_MAX+1)-1:0] eff_w,
  input  logic                          q_valid,
  input  logic [JOB_FLAGS_W+SAMPLE_BITS-1:0] q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_max,
  output logic signed [SAMPLE_BITS-1:0] out_min,
  output logic signed [SAMPLE_BITS-1:0] out_middle,
  output logic signed [SAMPLE_BITS-1:0] out_average,
  output logic                          out_last
);

  localparam int WIN_W = $clog2(WINDOW_MAX+1);
  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W = SAMPLE_BITS + WIN_W;
  localparam int CNT_W = $clog2(SUM_W);
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  back_state_t state_r, state_nxt;

  logic signed [SAMPLE_BITS-1:0] hist_r [WINDOW_MAX];
  logic [WIN_W-1:0]              j_r;
  logic signed [SAMPLE_BITS-1:0] mx_r, mn_r, mid_r;
  logic signed [SUM_W-1:0]       sum_r;
  logic                          neg_r;
  logic                          last_r;
  logic [WIN_W:0]                rem_r;
  logic [SUM_W-1:0]              quo_r;
  logic [CNT_W-1:0]              cnt_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_max_r, out_min_r, out_mid_r, out_avg_r;
  logic                          out_last_r;

  job_flags_t                    q_flags;
  logic signed [SAMPLE_BITS-1:0] q_sample;
  logic signed [SAMPLE_BITS-1:0] rd;
  logic [WIN_W-1:0]              mid_idx;
  logic                          scan_end;
  logic [WIN_W:0]                rem_sh;
  logic                          ge;
  logic                          out_load;
  logic [SUM_W-1:0]              avg_full;

  assign q_flags  = q_data[JOB_FLAGS_W+SAMPLE_BITS-1:SAMPLE_BITS];
  assign q_sample = q_data[SAMPLE_BITS-1:0];

  // Scan read port and window geometry
  assign rd       = hist_r[j_r[IDX_W-1:0]];
  assign mid_idx  = eff_w - WIN_W'(1) - (eff_w >> 1);
  assign scan_end = (j_r == eff_w - WIN_W'(1));

  // Restoring divide step on the sum magnitude
  assign rem_sh   = {rem_r[WIN_W-1:0], quo_r[SUM_W-1]};
  assign ge       = (rem_sh >= {1'b0, eff_w});
  assign avg_full = neg_r ? (SUM_W'(0) - quo_r) : quo_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && q_flags.produce) begin
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_end) begin
          state_nxt = BK_ABS;
        end
      end
      BK_ABS:  state_nxt = BK_DIV;
      BK_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        if (out_load) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      BK_IDLE: q_pop    = q_valid;
      BK_OUT:  out_load = !out_valid_r || out_ready;
      default: begin
        q_pop    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // History shift line, newest at entry 0
  always_ff @(posedge clk) begin
    if (q_pop) begin
      hist_r[0] <= q_sample;
      for (int i = 1; i < WINDOW_MAX; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  // Scan and divide datapath
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        j_r    <= '0;
        mx_r   <= S_MIN;
        mn_r   <= S_MAX;
        sum_r  <= '0;
        last_r <= q_flags.last;
      end
      BK_SCAN: begin
        j_r   <= j_r + WIN_W'(1);
        sum_r <= sum_r + SUM_W'(rd);
        if (rd > mx_r) begin
          mx_r <= rd;
        end
        if (rd < mn_r) begin
          mn_r <= rd;
        end
        if (j_r == mid_idx) begin
          mid_r <= rd;
        end
      end
      BK_ABS: begin
        neg_r <= sum_r[SUM_W-1];
        quo_r <= sum_r[SUM_W-1] ? (SUM_W'(0) - sum_r) : sum_r;
        rem_r <= '0;
        cnt_r <= CNT_W'(SUM_W - 1);
      end
      BK_DIV: begin
        rem_r <= ge ? (rem_sh - {1'b0, eff_w}) : rem_sh;
        quo_r <= {quo_r[SUM_W-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
      end
      default: begin
        j_r <= j_r;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_max_r  <= mx_r;
      out_min_r  <= mn_r;
      out_mid_r  <= mid_r;
      out_avg_r  <= avg_full[SAMPLE_BITS-1:0];
      out_last_r <= last_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_max     = out_max_r;
  assign out_min     = out_min_r;
  assign out_middle  = out_mid_r;
  assign out_average = out_avg_r;
  assign out_last    = out_last_r;

endmodule

@@ hw/rtl/sliding_window_statistics_core.sv @@
// Sliding-window max/min/middle/average core: top level with register port.
// A sample beat passes the front end and a two-entry queue between front and back;
// a beat that completes a window then runs the serial window scan, the sign and
// magnitude step and the one-bit-a-cycle divider, and waits until the result
// register is free. While the back end is busy the queue holds up to two further
// beats. Reset: window_size = 4, empty window, queue and output empty; no
// clearing pass.
module sliding_window_statistics_core
  import sws_pkg::*;
#(
  parameter int WINDOW_MAX  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  sws_in_if.sink                 in_bus,
  sws_out_if.source              out_bus,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  localparam int WIN_W = $clog2(WINDOW_MAX+1);
  localparam int JOB_W = JOB_FLAGS_W + SAMPLE_BITS;

  logic [WIN_REG_W-1:0] win_r, win_nxt;
  logic [WIN_W-1:0]     eff_w;
  logic                 cfg_wr;
  logic                 push_valid, push_ready;
  logic [JOB_W-1:0]     push_data;
  logic                 q_valid, q_pop;
  logic [JOB_W-1:0]     q_data;

  // Register port
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[CFG_ADDR_W-1] == REG_WINDOW_SIZE);
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1] == REG_WINDOW_SIZE) ?
                      CFG_DATA_W'(win_r) : '0;

  always_comb begin
    win_nxt = win_r;
    if (cfg_wr) begin
      win_nxt = cfg_pwdata[WIN_REG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WIN_REG_RESET;
    end else begin
      win_r <= win_nxt;
    end
  end

  // Effective window: zero reads as one, large values clamp
  always_comb begin
    if (win_r == '0) begin
      eff_w = WIN_W'(1);
    end else if (int'(win_r) > WINDOW_MAX) begin
      eff_w = WIN_W'(WINDOW_MAX);
    end else begin
      eff_w = WIN_W'(win_r);
    end
  end

  sws_front #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .eff_w      (eff_w),
    .cfg_clear  (cfg_wr),
    .in_valid   (in_bus.valid),
    .in_ready   (in_bus.ready),
    .in_sample  (in_bus.sample),
    .in_is_last (in_bus.is_last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sws_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  sws_back #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .eff_w       (eff_w),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_bus.valid),
    .out_ready   (out_bus.ready),
    .out_max     (out_bus.window_max),
    .out_min     (out_bus.window_min),
    .out_middle  (out_bus.window_middle),
    .out_average (out_bus.window_average),
    .out_last    (out_bus.end_of_sequence)
  );

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the sliding-window statistics core.
module tb
  import sws_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_MAX  = 16;
  localparam int SMP_BITS = 16;

  localparam logic signed [SMP_BITS-1:0] SMP_MAX = {1'b0, {(SMP_BITS-1){1'b1}}};
  localparam logic signed [SMP_BITS-1:0] SMP_MIN = {1'b1, {(SMP_BITS-1){1'b0}}};

  localparam logic [CFG_ADDR_W-1:0] WIN_ADDR = CFG_ADDR_W'(4 * int'(REG_WINDOW_SIZE));

  // Cycles to let the back end settle once the last result has come
  localparam int SETTLE_CYCLES   = 64;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 3000;
  localparam int RANDOM_ITEMS    = 400;
  localparam int MAX_PRINTED     = 100;

  typedef enum int {RX_STEADY, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  typedef struct {
    logic signed [SMP_BITS-1:0] wmax;
    logic signed [SMP_BITS-1:0] wmin;
    logic signed [SMP_BITS-1:0] wmid;
    logic signed [SMP_BITS-1:0] wavg;
    logic                       eos;
  } window_stats_t;

  logic clk;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  sws_in_if  #(.SAMPLE_BITS(SMP_BITS)) in_bus ();
  sws_out_if #(.SAMPLE_BITS(SMP_BITS)) out_bus ();

  sliding_window_statistics_core #(
    .WINDOW_MAX (WIN_MAX),
    .SAMPLE_BITS(SMP_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .out_bus    (out_bus),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Predictor state: own copy of history, fill level, sum and window register
  logic signed [SMP_BITS-1:0] hist [WIN_MAX];
  int                         fill_cnt;
  longint                     win_sum;
  logic [WIN_REG_W-1:0]       win_reg;

  window_stats_t expected_stats [$];

  int mismatch_count;
  int samples_sent;
  int results_checked;
  int settings_written;
  int burst_left;
  int hold_off_reqs;
  int hold_off_done;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Error reporting: one line per problem, log capped
  task automatic report_error(input string msg);
    if (mismatch_count < MAX_PRINTED)
      $display("[%0t] ERROR: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic int eff_window(input logic [WIN_REG_W-1:0] reg_val);
    if (reg_val == '0)
      return 1;
    if (reg_val > WIN_MAX)
      return WIN_MAX;
    return int'(reg_val);
  endfunction

  function automatic logic signed [SMP_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return SMP_BITS'(int'($urandom_range(0, 8)) - 4);
      default: return SMP_BITS'($urandom());
    endcase
  endfunction

  // Window statistics prediction for one accepted sample beat
  task automatic predict_window(input logic signed [SMP_BITS-1:0] smp, input logic last);
    int            w;
    int            i;
    longint        avg;
    window_stats_t beat;
    w = eff_window(win_reg);
    if (fill_cnt >= w) begin
      win_sum -= hist[w-1];
      fill_cnt = w - 1;
    end
    for (i = WIN_MAX - 1; i > 0; i--)
      hist[i] = hist[i-1];
    hist[0] = smp;
    win_sum += smp;
    fill_cnt++;
    if (fill_cnt == w) begin
      beat.wmax = hist[0];
      beat.wmin = hist[0];
      for (i = 1; i < w; i++) begin
        if (hist[i] > beat.wmax) beat.wmax = hist[i];
        if (hist[i] < beat.wmin) beat.wmin = hist[i];
      end
      beat.wmid = hist[w - 1 - w / 2];
      // signed division truncates toward zero
      avg = win_sum / w;
      beat.wavg = avg[SMP_BITS-1:0];
      beat.eos  = last;
      expected_stats.push_back(beat);
    end
    if (last) begin
      fill_cnt = 0;
      win_sum  = 0;
    end
  endtask

  // Sample sender: bursts of beats with random gaps between them
  task automatic send_sample(input logic signed [SMP_BITS-1:0] smp, input logic last);
    int gap;
    in_bus.sample  = smp;
    in_bus.is_last = last;
    in_bus.valid   = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    predict_window(smp, last);
    samples_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_bus.valid = 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic pause_input();
    if (in_bus.valid)
      in_bus.valid = 1'b0;
  endtask

  // Sender waits until every expected result beat has come
  task automatic wait_results();
    pause_input();
    do @(negedge clk); while (expected_stats.size() != 0);
  endtask

  // Block idle: no result outstanding and back end given time to finish
  task automatic drain_block();
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register access: setup cycle then access cycle
  task automatic cfg_access(input logic wr, input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = wr;
    cfg_paddr   = WIN_ADDR;
    cfg_pwdata  = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    if (wr) begin
      win_reg  = wdata[WIN_REG_W-1:0];
      fill_cnt = 0;
      win_sum  = 0;
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // New window size on an idle block, then read it back
  task automatic set_window(input int size);
    logic [CFG_DATA_W-1:0] wdata;
    logic [CFG_DATA_W-1:0] rdata;
    drain_block();
    wdata = CFG_DATA_W'(size);
    if ($urandom_range(0, 1))
      wdata[CFG_DATA_W-1:WIN_REG_W] = (CFG_DATA_W-WIN_REG_W)'($urandom());
    cfg_access(1'b1, wdata, rdata);
    cfg_access(1'b0, '0, rdata);
    if (rdata[WIN_REG_W-1:0] != wdata[WIN_REG_W-1:0])
      report_error($sformatf("window_size read back %0d, written %0d",
                             rdata[WIN_REG_W-1:0], wdata[WIN_REG_W-1:0]));
    settings_written++;
  endtask

  // Result checker: each result beat against the oldest expectation
  always @(posedge clk) begin
    window_stats_t              want;
    logic signed [SMP_BITS-1:0] got_f  [4];
    logic signed [SMP_BITS-1:0] want_f [4];
    string                      names  [4];
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_stats.size() == 0) begin
        report_error($sformatf("result beat with nothing expected (max %0d min %0d)",
                               out_bus.window_max, out_bus.window_min));
      end else begin
        want = expected_stats.pop_front();
        results_checked++;
        names  = '{"window_max", "window_min", "window_middle", "window_average"};
        got_f  = '{out_bus.window_max, out_bus.window_min,
                   out_bus.window_middle, out_bus.window_average};
        want_f = '{want.wmax, want.wmin, want.wmid, want.wavg};
        for (int f = 0; f < 4; f++)
          if (got_f[f] !== want_f[f])
            report_error($sformatf("result %0d %s: got %0d expected %0d",
                                   results_checked, names[f], got_f[f], want_f[f]));
        if (out_bus.end_of_sequence !== want.eos)
          report_error($sformatf("result %0d end_of_sequence: got %b expected %b",
                                 results_checked, out_bus.end_of_sequence, want.eos));
      end
    end
  end

  // Receiver: stall patterns in segments, plus long hold-offs on request
  initial begin
    rx_mode_t mode;
    int       seg_left;
    int       hold_left;
    int       period;
    int       phase_cnt;
    out_bus.ready = 1'b0;
    seg_left  = 0;
    hold_left = 0;
    period    = 2;
    phase_cnt = 0;
    mode      = RX_STEADY;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_bus.ready = 1'b0;
        hold_left--;
      end else if (hold_off_reqs != hold_off_done) begin
        out_bus.ready = 1'b0;
        hold_left = HOLD_OFF_CYCLES - 1;
        hold_off_done++;
      end else begin
        if (seg_left == 0) begin
          mode     = rx_mode_t'($urandom_range(0, 2));
          seg_left = $urandom_range(20, 200);
          period   = $urandom_range(2, 6);
        end
        seg_left--;
        phase_cnt++;
        case (mode)
          RX_STEADY:   out_bus.ready = 1'b1;
          RX_RANDOM:   out_bus.ready = ($urandom_range(0, 3) != 0);
          RX_PERIODIC: out_bus.ready = ((phase_cnt % period) != 0);
          default:     out_bus.ready = 1'b1;
        endcase
      end
    end
  end

  // Watchdog: too long without any beat or register access
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_psel && cfg_penable && cfg_pready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[%0t] watchdog: no progress for %0d cycles", $realtime, idle_cycles);
        $display("sliding_window_statistics_core test failed");
        $finish;
      end
    end
  end

  // Extremes of the sample range, short sequences, zero and saturated window sizes
  task automatic test_directed();
    int k;
    // default window of four straight after reset
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b0);
    send_sample('0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd5, 1'b1);
    // sequence ends before the window fills: no result
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd9, 1'b1);
    // size zero behaves as a window of one
    set_window(0);
    send_sample(SMP_MIN, 1'b0);
    send_sample(SMP_MAX, 1'b1);
    // negative sum, average truncates toward zero
    set_window(3);
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample('0, 1'b1);
    // size above the maximum saturates; full-scale sum
    set_window(20);
    for (k = 0; k < WIN_MAX; k++)
      send_sample(SMP_MAX, k == WIN_MAX - 1);
  endtask

  // Receiver holds off for a long stretch while samples keep coming
  task automatic test_receiver_hold_off();
    int k;
    set_window(2);
    hold_off_reqs++;
    for (k = 0; k < 24; k++)
      send_sample(pick_sample(), k == 23);
  endtask

  // Sender stops mid-sequence until all results are in, then carries on
  task automatic test_sender_pause();
    int k;
    set_window(5);
    for (k = 0; k < 12; k++)
      send_sample(pick_sample(), 1'b0);
    wait_results();
    for (k = 0; k < 12; k++)
      send_sample(pick_sample(), k == 11);
  endtask

  // Random phases: mostly full sequences, some short ones and random noise
  task automatic test_random_sequences();
    int phase;
    int done_items;
    int target;
    int w_cfg;
    int w;
    int len;
    int kind;
    int k;
    logic last;
    phase      = 0;
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      case (phase)
        0:       w_cfg = WIN_MAX;
        1:       w_cfg = 1;
        2:       w_cfg = 31;
        3:       w_cfg = 0;
        4:       w_cfg = WIN_MAX + 1;
        default: w_cfg = $urandom_range(0, 1) ? $urandom_range(1, 5) : $urandom_range(0, 31);
      endcase
      set_window(w_cfg);
      w      = eff_window(WIN_REG_W'(w_cfg));
      target = done_items + $urandom_range(30, 60);
      while (done_items < target) begin
        kind = $urandom_range(0, 9);
        if (kind < 8)
          len = $urandom_range(w, 3 * w + 2);
        else if (kind == 8)
          len = (w > 1) ? $urandom_range(1, w - 1) : 1;
        else
          len = $urandom_range(1, 2 * w);
        for (k = 0; k < len; k++) begin
          if (kind < 9)
            last = (k == len - 1);
          else
            last = ($urandom_range(0, 5) == 0);
          send_sample(pick_sample(), last);
          done_items++;
        end
      end
      if ($urandom_range(0, 3) == 0)
        wait_results();
      phase++;
    end
  endtask

  // Main sequence
  initial begin
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.sample  = '0;
    in_bus.is_last = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    for (int i = 0; i < WIN_MAX; i++)
      hist[i] = '0;
    fill_cnt         = 0;
    win_sum          = 0;
    win_reg          = WIN_REG_RESET;
    mismatch_count   = 0;
    samples_sent     = 0;
    results_checked  = 0;
    settings_written = 0;
    burst_left       = 0;
    hold_off_reqs    = 0;
    hold_off_done    = 0;

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_receiver_hold_off();
    test_sender_pause();
    test_random_sequences();

    drain_block();
    if (expected_stats.size() != 0)
      report_error($sformatf("%0d result beats never arrived", expected_stats.size()));

    $display("Covered %0d sample beats and %0d result beats over %0d window settings,",
             samples_sent, results_checked, settings_written);
    $display("with zero, unit, full and saturated windows, receiver hold-off and sender pauses.");
    if (mismatch_count == 0) begin
      $display("sliding_window_statistics_core test passed");
    end else begin
      $display("%0d errors", mismatch_count);
      $display("sliding_window_statistics_core test failed");
    end
    $finish;
  end

endmodule
